// ----- hw/rtl/stg_pkg.sv -----
// shared types, constants and the note period table of the square tone generator
package stg_pkg;

	// stream word layout
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 2;

	// input field widths
	localparam int OPCODE_W = 2;
	localparam int NOTE_W   = 9;
	localparam int DUR_IN_W = 17;
	localparam int VOL_IN_W = 9;

	// datapath widths
	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 27;
	localparam int AMP_W    = 15;
	localparam int VOL_W    = 7;

	localparam int NOTE_MAX    = 127;
	localparam int VOL_MAX     = 100;
	localparam int AMP_PER_VOL = 200;
	localparam int PHASE_ONE   = 65536;

	// opcodes, any other code is a tick
	localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_STOP  = 2'd2;

	// classified command kinds
	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_START,
		CMD_STOP,
		CMD_REJECT
	} cmd_kind_t;

	// period table: 16000/f in q11.16, rounded
	localparam int NOTE_COUNT = 128;
	localparam int SEMITONES  = 12;
	localparam int ROM_NOTE_BASE   = 189;
	localparam int ROM_SHIFT_BASE  = 6;
	localparam logic [63:0] RATIO_MUL  = 64'd400;
	localparam logic [63:0] ROUND_HALF = 64'd5500000000;
	localparam logic [63:0] ROUND_DIV  = 64'd11000000000;

	typedef logic [63:0] ratio_table_t [SEMITONES];
	typedef logic [PHASE_W-1:0] period_rom_t [NOTE_COUNT];

	// 2^(k/12) scaled by 1e9
	localparam ratio_table_t SEMITONE_RATIO = '{
		64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
		64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
		64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
	};

	function automatic period_rom_t build_period_rom();
		period_rom_t rom;
		logic [63:0] num;
		int          m;
		int          q;
		int          k;
		for (int n = 0; n < NOTE_COUNT; n++) begin
			m   = ROM_NOTE_BASE - n;
			q   = m / SEMITONES;
			k   = m % SEMITONES;
			num = (RATIO_MUL * SEMITONE_RATIO[k]) << (q + ROM_SHIFT_BASE);
			rom[n] = PHASE_W'((num + ROUND_HALF) / ROUND_DIV);
		end
		return rom;
	endfunction

	localparam period_rom_t PERIOD_ROM = build_period_rom();

endpackage

// ----- hw/rtl/stg_front.sv -----
// front end: takes input words, checks and clamps start arguments, looks up the note period
module stg_front #(
	parameter int MAX_DURATION_MS = 10000,
	parameter int SAMPLES_PER_MS  = 16,
	parameter int FADE_SAMPLES    = 80,
	parameter int TOTAL_W         = 18,
	parameter int FADE_W          = 7
) (
	input  logic                              in_valid,
	output logic                              in_ready,
	// note_number, duration, volume_percent from bit 0 up
	input  logic [stg_pkg::S_TDATA_W-1:0]     in_data,
	// opcode
	input  logic [stg_pkg::S_TUSER_W-1:0]     in_user,
	input  logic                              q_full,
	output logic                              push,
	output stg_pkg::cmd_kind_t                cmd_kind,
	output logic [TOTAL_W-1:0]                cmd_total,
	output logic [stg_pkg::AMP_W-1:0]         cmd_amp,
	output logic [FADE_W-1:0]                 cmd_fade,
	output logic [stg_pkg::PHASE_W-1:0]       cmd_period
);
	import stg_pkg::*;

	localparam int DUR_W = $clog2(MAX_DURATION_MS + 1);
	localparam int CMP_W = TOTAL_W + FADE_W;

	logic [OPCODE_W-1:0] opcode;
	logic [NOTE_W-1:0]   note_number;
	logic [DUR_IN_W-1:0] dur_in;
	logic [VOL_IN_W-1:0] volume_percent;
	logic                note_bad;
	logic                dur_bad;
	logic [DUR_W-1:0]    dur_c;
	logic [VOL_W-1:0]    vol_c;
	logic [TOTAL_W-1:0]  half;

	assign opcode         = in_user[OPCODE_W-1:0];
	assign note_number    = in_data[NOTE_W-1:0];
	assign dur_in         = in_data[NOTE_W+DUR_IN_W-1:NOTE_W];
	assign volume_percent = in_data[NOTE_W+DUR_IN_W+VOL_IN_W-1:NOTE_W+DUR_IN_W];

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// sign bit set means negative
	assign note_bad = note_number[NOTE_W-1] || (note_number > NOTE_W'(NOTE_MAX));
	assign dur_bad  = dur_in[DUR_IN_W-1] || (dur_in == '0);

	always_comb begin
		if (dur_in > DUR_IN_W'(MAX_DURATION_MS)) begin
			dur_c = DUR_W'(MAX_DURATION_MS);
		end else begin
			dur_c = DUR_W'(dur_in);
		end
		if (volume_percent[VOL_IN_W-1]) begin
			vol_c = '0;
		end else if (volume_percent > VOL_IN_W'(VOL_MAX)) begin
			vol_c = VOL_W'(VOL_MAX);
		end else begin
			vol_c = VOL_W'(volume_percent);
		end
	end

	assign cmd_total  = TOTAL_W'(dur_c * SAMPLES_PER_MS);
	assign cmd_amp    = AMP_W'(vol_c * AMP_PER_VOL);
	assign half       = cmd_total >> 1;
	assign cmd_fade   = (CMP_W'(half) < CMP_W'(FADE_SAMPLES)) ? FADE_W'(half)
	                                                          : FADE_W'(FADE_SAMPLES);
	assign cmd_period = PERIOD_ROM[note_number[6:0]];

	always_comb begin
		unique case (opcode)
			OP_START: cmd_kind = (note_bad || dur_bad) ? CMD_REJECT : CMD_START;
			OP_STOP:  cmd_kind = CMD_STOP;
			default:  cmd_kind = CMD_TICK;
		endcase
	end

endmodule

// ----- hw/rtl/stg_queue.sv -----
// two-entry command queue between front and back end
module stg_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output logic [DATA_W-1:0] pop_data
);
	localparam int DEPTH = 2;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == 2'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd0 || count_q == 2'd1 || count_q == 2'd2)
		else $error("queue count out of range");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count missed a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

// ----- hw/rtl/stg_back.sv -----
// back end: tone state, square wave, serial fade divider and output register
module stg_back #(
	parameter int UPSAMPLE_FACTOR = 3,
	parameter int TOTAL_W         = 18,
	parameter int FADE_W          = 7,
	parameter int REP_W           = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  stg_pkg::cmd_kind_t            cmd_kind,
	input  logic [TOTAL_W-1:0]            cmd_total,
	input  logic [stg_pkg::AMP_W-1:0]     cmd_amp,
	input  logic [FADE_W-1:0]             cmd_fade,
	input  logic [stg_pkg::PHASE_W-1:0]   cmd_period,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_status,
	output logic                          out_frame,
	output logic [stg_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                          out_last,
	output logic                          out_busy
);
	import stg_pkg::*;

	localparam int CNT_W  = $clog2(AMP_W);
	localparam int PROD_W = AMP_W + FADE_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_FRAME = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t               state_q;

	// tone state
	logic                 playing_q;
	logic                 stop_pending_q;
	logic [TOTAL_W-1:0]   idx_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [FADE_W-1:0]    fade_q;
	logic [AMP_W-1:0]     amp_q;
	logic [REP_W-1:0]     rep_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [PHASE_W-1:0]   period_q;
	logic [SAMPLE_W-1:0]  held_q;

	// work registers
	logic                 new_smp_q;
	logic                 high_q;
	logic [AMP_W-1:0]     mag_q;
	logic [FADE_W-1:0]    fade_n_q;
	logic [AMP_W-1:0]     dvd_q;
	logic [FADE_W-1:0]    rem_q;
	logic [CNT_W-1:0]     cnt_q;

	// finished result waiting for the output register
	logic                 res_status_q;
	logic                 res_frame_q;
	logic [SAMPLE_W-1:0]  res_sample_q;
	logic                 res_last_q;
	logic                 res_busy_q;

	logic                 out_valid_q;
	logic                 out_status_q;
	logic                 out_frame_q;
	logic [SAMPLE_W-1:0]  out_sample_q;
	logic                 out_last_q;
	logic                 out_busy_q;

	logic [PHASE_W:0]     phase_sum;
	logic                 phase_wrap;
	logic                 fade_in;
	logic                 fade_out;
	logic [PROD_W-1:0]    product;
	logic [FADE_W:0]      trial;
	logic                 trial_ge;
	logic [SAMPLE_W-1:0]  frame_smp;
	logic [REP_W:0]       rep_inc;
	logic [TOTAL_W:0]     idx_inc;
	logic                 tick_stop;
	logic                 smp_done;
	logic                 tone_done;
	logic                 emit;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	assign phase_sum  = {1'b0, phase_q} + (PHASE_W+1)'(PHASE_ONE);
	assign phase_wrap = phase_sum >= {1'b0, period_q};
	assign fade_in    = (fade_q != '0) && (idx_q < TOTAL_W'(fade_q));
	assign fade_out   = (fade_q != '0) && (idx_q >= total_q - TOTAL_W'(fade_q));

	assign product  = PROD_W'(amp_q) * PROD_W'(fade_n_q);
	assign trial    = {rem_q, dvd_q[AMP_W-1]};
	assign trial_ge = trial >= {1'b0, fade_q};

	assign frame_smp = !new_smp_q ? held_q
	                 : (high_q ? SAMPLE_W'(mag_q) : -SAMPLE_W'(mag_q));
	assign rep_inc   = {1'b0, rep_q} + (REP_W+1)'(1);
	assign idx_inc   = {1'b0, idx_q} + (TOTAL_W+1)'(1);

	// pending stop seen by a tick on a sample boundary
	assign tick_stop = playing_q && (rep_q == '0) && stop_pending_q;
	// last repeat of a source sample, and of the final source sample
	assign smp_done  = rep_inc >= (REP_W+1)'(UPSAMPLE_FACTOR);
	assign tone_done = smp_done && (idx_inc >= {1'b0, total_q});

	// finished word moves into the output register
	assign emit = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			playing_q      <= 1'b0;
			stop_pending_q <= 1'b0;
			idx_q          <= '0;
			total_q        <= '0;
			fade_q         <= '0;
			amp_q          <= '0;
			rep_q          <= '0;
			phase_q        <= '0;
			period_q       <= '0;
			held_q         <= '0;
			new_smp_q      <= 1'b0;
			high_q         <= 1'b0;
			mag_q          <= '0;
			fade_n_q       <= '0;
			dvd_q          <= '0;
			rem_q          <= '0;
			cnt_q          <= '0;
			res_status_q   <= 1'b0;
			res_frame_q    <= 1'b0;
			res_sample_q   <= '0;
			res_last_q     <= 1'b0;
			res_busy_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (q_valid) begin
					res_status_q <= (cmd_kind == CMD_REJECT);
					res_frame_q  <= 1'b0;
					res_sample_q <= '0;
					res_last_q   <= (cmd_kind == CMD_TICK) && tick_stop;
					res_busy_q   <= (cmd_kind == CMD_START)
					             || (playing_q && !((cmd_kind == CMD_TICK) && tick_stop));
					case (cmd_kind)
						CMD_START: begin
							total_q        <= cmd_total;
							amp_q          <= cmd_amp;
							fade_q         <= cmd_fade;
							period_q       <= cmd_period;
							phase_q        <= '0;
							idx_q          <= '0;
							rep_q          <= '0;
							held_q         <= '0;
							stop_pending_q <= 1'b0;
							playing_q      <= 1'b1;
							state_q        <= ST_EMIT;
						end
						CMD_REJECT: begin
							state_q <= ST_EMIT;
						end
						CMD_STOP: begin
							if (playing_q) begin
								stop_pending_q <= 1'b1;
							end
							state_q <= ST_EMIT;
						end
						default: begin
							if (!playing_q) begin
								// idle tick: empty result
								state_q <= ST_EMIT;
							end else if (tick_stop) begin
								// stop lands on a sample boundary
								playing_q      <= 1'b0;
								stop_pending_q <= 1'b0;
								state_q        <= ST_EMIT;
							end else if (rep_q == '0) begin
								new_smp_q <= 1'b1;
								high_q    <= {phase_q, 1'b0} < {1'b0, period_q};
								phase_q   <= phase_wrap
								           ? PHASE_W'(phase_sum - {1'b0, period_q})
								           : PHASE_W'(phase_sum);
								if (fade_in) begin
									fade_n_q <= FADE_W'(idx_q);
									state_q  <= ST_MUL;
								end else if (fade_out) begin
									fade_n_q <= FADE_W'(total_q - idx_q);
									state_q  <= ST_MUL;
								end else begin
									mag_q   <= amp_q;
									state_q <= ST_FRAME;
								end
							end else begin
								new_smp_q <= 1'b0;
								state_q   <= ST_FRAME;
							end
						end
					endcase
				end
				ST_MUL: begin
					// quotient fits amp width, so the top bits start below the divisor
					rem_q   <= product[PROD_W-1:AMP_W];
					dvd_q   <= product[AMP_W-1:0];
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= trial_ge ? FADE_W'(trial - {1'b0, fade_q}) : FADE_W'(trial);
					dvd_q <= {dvd_q[AMP_W-2:0], trial_ge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(AMP_W - 1)) begin
						mag_q   <= {dvd_q[AMP_W-2:0], trial_ge};
						state_q <= ST_FRAME;
					end
				end
				ST_FRAME: begin
					held_q       <= frame_smp;
					res_frame_q  <= 1'b1;
					res_sample_q <= frame_smp;
					res_last_q   <= tone_done;
					res_busy_q   <= !tone_done;
					if (smp_done) begin
						rep_q <= '0;
						idx_q <= TOTAL_W'(idx_inc);
					end else begin
						rep_q <= REP_W'(rep_inc);
					end
					if (tone_done) begin
						playing_q      <= 1'b0;
						stop_pending_q <= 1'b0;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register, refilled in the cycle the sink takes the old word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_frame_q  <= 1'b0;
			out_sample_q <= '0;
			out_last_q   <= 1'b0;
			out_busy_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_frame_q  <= res_frame_q;
				out_sample_q <= res_sample_q;
				out_last_q   <= res_last_q;
				out_busy_q   <= res_busy_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_frame  = out_frame_q;
	assign out_sample = out_sample_q;
	assign out_last   = out_last_q;
	assign out_busy   = out_busy_q;

`ifndef NO_ASSERTIONS
	a_stop_needs_tone: assert property (@(posedge clk) disable iff (!arst_n)
		stop_pending_q |-> playing_q)
		else $error("stop pending without a tone");
	a_index_in_tone: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> (idx_q < total_q))
		else $error("sample index ran past the tone");
	a_fade_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRAME && new_smp_q) |-> (mag_q <= amp_q))
		else $error("faded magnitude above amplitude");
	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("output loaded outside emit");
`endif

endmodule

// ----- hw/rtl/square_tone_generator_with_fade.sv -----
// top level of the square tone generator with linear fade
//
//  channel  | handshake                   | word contents
//  ---------+-----------------------------+------------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready | tuser opcode, tdata note/duration/volume
//  m_axis   | m_axis_tvalid/m_axis_tready | tuser status/frame_valid, tdata samples
//           |                             | and busy_res, tlast last_frame
//
// every input word gives exactly one output word, in order.
// start, stop, rejected start, an idle tick and the tick that ends a stopped
// tone go from idle straight to emit in the back end; a tick that repeats a held
// sample, or starts a sample without fade, passes through frame before emit.
// a tick that starts a faded sample passes through mul, div, frame and emit; the
// fade divider resolves one quotient bit per cycle over the 15-bit amplitude.
// a two-word queue decouples input acceptance from the back end, and the output
// register lets the back end finish the next word while the sink stalls.
// arst_n clears all state but the queue storage; the block comes up idle and silent.
module square_tone_generator_with_fade #(
	parameter int MAX_DURATION_MS = 10000,
	parameter int SAMPLES_PER_MS  = 16,
	parameter int UPSAMPLE_FACTOR = 3,
	parameter int FADE_SAMPLES    = 80
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// note_number [8:0], duration [25:9], volume_percent [34:26], zero fill
	input  logic [stg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// opcode [1:0]
	input  logic [stg_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// left_sample [15:0], right_sample [31:16], busy_res [32], zero fill
	output logic [stg_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// status [0], frame_valid [1]
	output logic [stg_pkg::M_TUSER_W-1:0]  m_axis_tuser,
	// last_frame
	output logic                           m_axis_tlast
);
	import stg_pkg::*;

	localparam int TOTAL_W = $clog2(MAX_DURATION_MS * SAMPLES_PER_MS + 1);
	localparam int FADE_W  = $clog2(FADE_SAMPLES + 1);
	localparam int REP_W   = $clog2(UPSAMPLE_FACTOR + 1);
	localparam int KIND_W  = $bits(cmd_kind_t);
	localparam int CMD_W   = KIND_W + TOTAL_W + AMP_W + FADE_W + PHASE_W;

	// front end outputs
	logic                 push;
	logic                 q_full;
	cmd_kind_t            f_kind;
	logic [TOTAL_W-1:0]   f_total;
	logic [AMP_W-1:0]     f_amp;
	logic [FADE_W-1:0]    f_fade;
	logic [PHASE_W-1:0]   f_period;

	// queue outputs toward the back end
	logic [CMD_W-1:0]     push_word;
	logic [CMD_W-1:0]     pop_word;
	logic                 q_valid;
	logic                 q_pop;
	cmd_kind_t            b_kind;
	logic [TOTAL_W-1:0]   b_total;
	logic [AMP_W-1:0]     b_amp;
	logic [FADE_W-1:0]    b_fade;
	logic [PHASE_W-1:0]   b_period;

	logic                 out_status;
	logic                 out_frame;
	logic [SAMPLE_W-1:0]  out_sample;
	logic                 out_busy;

	stg_front #(
		.MAX_DURATION_MS (MAX_DURATION_MS),
		.SAMPLES_PER_MS  (SAMPLES_PER_MS),
		.FADE_SAMPLES    (FADE_SAMPLES),
		.TOTAL_W         (TOTAL_W),
		.FADE_W          (FADE_W)
	) u_front (
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_user    (s_axis_tuser),
		.q_full     (q_full),
		.push       (push),
		.cmd_kind   (f_kind),
		.cmd_total  (f_total),
		.cmd_amp    (f_amp),
		.cmd_fade   (f_fade),
		.cmd_period (f_period)
	);

	assign push_word = {f_period, f_fade, f_amp, f_total, f_kind};

	stg_queue #(
		.DATA_W (CMD_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (pop_word)
	);

	assign {b_period, b_fade, b_amp, b_total} = pop_word[CMD_W-1:KIND_W];
	assign b_kind = cmd_kind_t'(pop_word[KIND_W-1:0]);

	stg_back #(
		.UPSAMPLE_FACTOR (UPSAMPLE_FACTOR),
		.TOTAL_W         (TOTAL_W),
		.FADE_W          (FADE_W),
		.REP_W           (REP_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.cmd_kind   (b_kind),
		.cmd_total  (b_total),
		.cmd_amp    (b_amp),
		.cmd_fade   (b_fade),
		.cmd_period (b_period),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (out_status),
		.out_frame  (out_frame),
		.out_sample (out_sample),
		.out_last   (m_axis_tlast),
		.out_busy   (out_busy)
	);

	// both channels carry the same sample
	assign m_axis_tdata = {{(M_TDATA_W - 2 * SAMPLE_W - 1){1'b0}}, out_busy,
	                       out_sample, out_sample};
	assign m_axis_tuser = {out_frame, out_status};

endmodule

// ----- verif/square_tone_generator_with_fade_tb.sv -----
// self-checking stream testbench for the square tone generator with linear fade
module square_tone_generator_with_fade_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// block configuration, kept at the defaults of the design
	localparam int MAX_MS     = 10000;
	localparam int SAMPLES_MS = 16;
	localparam int REPEATS    = 3;
	localparam int FADE_MAX   = 80;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int RANDOM_WORDS = 750;
	localparam int DRAIN_CYCLES = 64;

	// a tick is any code other than start and stop; code 3 is the spare tick
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_TICK_ALT = 2'd3;

	// one result word, unpacked from the master side
	typedef struct packed {
		logic        status;
		logic        frame_valid;
		logic [15:0] left_sample;
		logic [15:0] right_sample;
		logic        last_frame;
		logic        busy;
	} tone_word_t;

	localparam tone_word_t QUIET       = '{1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0};
	localparam tone_word_t BUSY        = '{1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b1};
	localparam tone_word_t REJECT_IDLE = '{1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0};
	localparam tone_word_t REJECT_BUSY = '{1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b1};

	// one row of the directed part; want is only used where typed is set
	typedef struct packed {
		logic [1:0]  op;
		logic [8:0]  note;
		logic [16:0] dur;
		logic [8:0]  vol;
		logic        typed;
		tone_word_t  want;
	} stim_row_t;

	localparam int DIR_ROWS = 25;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		// idle behavior right after reset
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b1, QUIET},
		'{stg_pkg::OP_STOP,  9'd0,    17'd0,      9'd0,    1'b1, QUIET},
		// rejected starts: note below zero, above 127, duration zero or negative
		'{stg_pkg::OP_START, 9'h1FF,  17'd100,    9'd50,   1'b1, REJECT_IDLE},
		'{stg_pkg::OP_START, 9'd128,  17'd100,    9'd50,   1'b1, REJECT_IDLE},
		'{stg_pkg::OP_START, 9'h100,  17'd1,      9'd50,   1'b1, REJECT_IDLE},
		'{stg_pkg::OP_START, 9'd60,   17'd0,      9'd50,   1'b1, REJECT_IDLE},
		'{stg_pkg::OP_START, 9'd60,   17'h10000,  9'd50,   1'b1, REJECT_IDLE},
		// spare opcode acts as a tick, fields all ones are ignored
		'{OP_TICK_ALT,       9'h1FF,  17'h1FFFF,  9'h1FF,  1'b1, QUIET},
		// lowest note, shortest tone, volume clamped up to zero
		'{stg_pkg::OP_START, 9'd0,    17'd1,      9'h100,  1'b1, BUSY},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		// start while playing, highest note, duration and volume clamped down
		'{stg_pkg::OP_START, 9'd127,  17'd65535,  9'd255,  1'b1, BUSY},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		// stop in the middle of a repeated sample, honored at the boundary
		'{stg_pkg::OP_START, 9'd69,   17'd1,      9'd100,  1'b1, BUSY},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		'{stg_pkg::OP_STOP,  9'd0,    17'd0,      9'd0,    1'b1, BUSY},
		'{OP_TICK_ALT,       9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b0, QUIET},
		'{OP_TICK,           9'd0,    17'd0,      9'd0,    1'b1, QUIET},
		// rejected start while playing keeps the tone, then a stop is left pending
		'{stg_pkg::OP_START, 9'd60,   17'd1,      9'd100,  1'b1, BUSY},
		'{stg_pkg::OP_START, 9'd200,  17'd10,     9'd10,   1'b1, REJECT_BUSY},
		'{stg_pkg::OP_STOP,  9'd0,    17'd0,      9'd0,    1'b1, BUSY}
	};

	// 2^(k/12) scaled by 1e9, used to rebuild the note periods
	localparam longint unsigned SEMI_RATIO [12] = '{
		64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
		64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
		64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
	};

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// note_number [8:0], duration [25:9], volume_percent [34:26], zero fill
	logic [stg_pkg::S_TDATA_W-1:0] s_axis_tdata;
	// opcode [1:0]
	logic [stg_pkg::S_TUSER_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// left_sample [15:0], right_sample [31:16], busy_res [32], zero fill
	logic [stg_pkg::M_TDATA_W-1:0] m_axis_tdata;
	// status [0], frame_valid [1]
	logic [stg_pkg::M_TUSER_W-1:0] m_axis_tuser;
	// last_frame
	logic m_axis_tlast;

	// predictor state: the tone currently armed
	logic        tone_on;
	logic        stop_req;
	int unsigned smp_idx;
	int unsigned smp_total;
	int unsigned fade_len;
	int unsigned amp;
	int unsigned rep;
	int unsigned phase;
	int unsigned period;
	logic [15:0] held;

	tone_word_t tone_words_due [$];
	tone_word_t got_word;
	tone_word_t want_word;
	int         mismatch_count;
	int         cycle_count;
	int         words_sent;
	bit         steady_flow;

	square_tone_generator_with_fade #(
		.MAX_DURATION_MS(MAX_MS),
		.SAMPLES_PER_MS (SAMPLES_MS),
		.UPSAMPLE_FACTOR(REPEATS),
		.FADE_SAMPLES   (FADE_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// period of a note in q11.16 source samples, rounded to nearest
	function automatic int unsigned note_period_q16(int n);
		longint unsigned scaled;
		int              steps;
		steps  = 189 - n;
		scaled = (64'd400 * SEMI_RATIO[steps % 12]) << (steps / 12 + 6);
		return int'((scaled + 64'd5500000000) / 64'd11000000000);
	endfunction

	// advances the tone state by one accepted word and returns its result
	function automatic tone_word_t predict_tone_word(logic [1:0] op, logic [8:0] nt,
			logic [16:0] du, logic [8:0] vo);
		tone_word_t      w;
		int              nv;
		int              dv;
		int              vv;
		int unsigned     half;
		longint unsigned mag;
		logic            rise;
		w  = QUIET;
		nv = $signed(nt);
		dv = $signed(du);
		vv = $signed(vo);
		if (op == stg_pkg::OP_START) begin
			if (nv < 0 || nv > stg_pkg::NOTE_MAX || dv <= 0) begin
				w.status = 1'b1;
			end else begin
				if (dv > MAX_MS) dv = MAX_MS;
				if (vv < 0) vv = 0;
				if (vv > stg_pkg::VOL_MAX) vv = stg_pkg::VOL_MAX;
				smp_total = dv * SAMPLES_MS;
				amp       = stg_pkg::AMP_PER_VOL * vv;
				half      = smp_total / 2;
				fade_len  = (FADE_MAX < half) ? FADE_MAX : half;
				period    = note_period_q16(nv);
				phase     = 0;
				smp_idx   = 0;
				rep       = 0;
				held      = '0;
				stop_req  = 1'b0;
				tone_on   = 1'b1;
			end
		end else if (op == stg_pkg::OP_STOP) begin
			if (tone_on) stop_req = 1'b1;
		end else if (tone_on) begin
			if (rep == 0 && stop_req) begin
				// stop honored at a sample boundary: no frame, just the end marker
				tone_on    = 1'b0;
				stop_req   = 1'b0;
				w.last_frame = 1'b1;
			end else begin
				if (rep == 0) begin
					// new source sample: square level, then linear fade in or out
					rise = (64'(phase) * 2) < 64'(period);
					mag  = amp;
					if (fade_len != 0) begin
						if (smp_idx < fade_len)
							mag = (64'(amp) * smp_idx) / fade_len;
						else if (smp_idx >= smp_total - fade_len)
							mag = (64'(amp) * (smp_total - smp_idx)) / fade_len;
					end
					phase = phase + stg_pkg::PHASE_ONE;
					if (phase >= period) phase = phase - period;
					held = rise ? 16'(mag) : 16'(-mag);
				end
				w.frame_valid  = 1'b1;
				w.left_sample  = held;
				w.right_sample = held;
				rep++;
				if (rep >= REPEATS) begin
					rep = 0;
					smp_idx++;
					if (smp_idx >= smp_total) begin
						tone_on      = 1'b0;
						stop_req     = 1'b0;
						w.last_frame = 1'b1;
					end
				end
			end
		end
		w.busy = tone_on;
		return w;
	endfunction

	// offers one word on the slave side, with random gaps before it
	task automatic send_word(logic [1:0] op, logic [8:0] nt, logic [16:0] du, logic [8:0] vo,
			bit typed = 1'b0, tone_word_t want = '0);
		tone_word_t pred;
		while (!steady_flow && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {5'd0, vo, du, nt};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pred = predict_tone_word(op, nt, du, vo);
		tone_words_due.push_back(typed ? want : pred);
		words_sent++;
	endtask

	// a run of ticks, now and then with the spare tick code
	task automatic tick_run(int count);
		for (int t = 0; t < count; t++)
			send_word(($urandom_range(9) == 0) ? OP_TICK_ALT : OP_TICK,
				9'($urandom), 17'($urandom), 9'($urandom));
	endtask

	// sink: random back-pressure, checks every accepted word in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_word.status       = m_axis_tuser[0];
				got_word.frame_valid  = m_axis_tuser[1];
				got_word.left_sample  = m_axis_tdata[15:0];
				got_word.right_sample = m_axis_tdata[31:16];
				got_word.last_frame   = m_axis_tlast;
				got_word.busy         = m_axis_tdata[32];
				if (tone_words_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected word: status %0b frame %0b left %0d last %0b busy %0b",
							got_word.status, got_word.frame_valid,
							$signed(got_word.left_sample), got_word.last_frame, got_word.busy);
				end else begin
					want_word = tone_words_due.pop_front();
					if (got_word !== want_word) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"word mismatch: expected st %0b fv %0b l %0d r %0d lf %0b bz %0b,",
								" got st %0b fv %0b l %0d r %0d lf %0b bz %0b"},
								want_word.status, want_word.frame_valid,
								$signed(want_word.left_sample), $signed(want_word.right_sample),
								want_word.last_frame, want_word.busy,
								got_word.status, got_word.frame_valid,
								$signed(got_word.left_sample), $signed(got_word.right_sample),
								got_word.last_frame, got_word.busy);
					end
				end
			end
			m_axis_tready <= steady_flow || ($urandom_range(99) >= 30);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int          kind;
		int          n;
		int          dsel;
		int          vsel;
		logic [8:0]  nt;
		logic [16:0] du;
		logic [8:0]  vo;

		arst_n         <= 1'b0;
		s_axis_tvalid  <= 1'b0;
		s_axis_tdata   <= '0;
		s_axis_tuser   <= OP_TICK;
		tone_on        = 1'b0;
		stop_req       = 1'b0;
		smp_idx        = 0;
		smp_total      = 0;
		fade_len       = 0;
		amp            = 0;
		rep            = 0;
		phase          = 0;
		period         = 0;
		held           = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		words_sent     = 0;
		steady_flow    = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int r = 0; r < DIR_ROWS; r++)
			send_word(DIR_TABLE[r].op, DIR_TABLE[r].note, DIR_TABLE[r].dur, DIR_TABLE[r].vol,
				DIR_TABLE[r].typed, DIR_TABLE[r].want);

		// random part: mostly whole tones with random content, some noise
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			// a stretch where neither side idles
			steady_flow = (words_sent >= 250 && words_sent < 400);
			kind = $urandom_range(99);
			if (kind < 70) begin
				nt   = 9'($urandom_range(0, stg_pkg::NOTE_MAX));
				dsel = $urandom_range(99);
				if (dsel < 60)
					du = 17'd1;
				else if (dsel < 75)
					du = 17'($urandom_range(2, 12));
				else if (dsel < 90)
					du = 17'($urandom_range(MAX_MS + 1, 65535));
				else
					du = 17'($urandom_range(13, MAX_MS));
				vsel = $urandom_range(99);
				if (vsel < 60)
					vo = 9'($urandom_range(0, stg_pkg::VOL_MAX));
				else if (vsel < 80)
					vo = 9'($urandom_range(stg_pkg::VOL_MAX + 1, 255));
				else
					vo = 9'($urandom_range(256, 511));
				send_word(stg_pkg::OP_START, nt, du, vo);
				if (du <= 17'd2 && $urandom_range(99) < 75) begin
					// play the tone out to its last frame, at times a little past it
					tick_run(REPEATS * SAMPLES_MS * int'(du) + $urandom_range(0, 3));
				end else begin
					// long runs reach late into the full-length fade-in, or past it
					n = ($urandom_range(99) < 8) ? $urandom_range(200, 320) : $urandom_range(1, 60);
					tick_run(n);
					if ($urandom_range(1) == 1) begin
						send_word(stg_pkg::OP_STOP, 9'($urandom), 17'($urandom), 9'($urandom));
						tick_run($urandom_range(0, 5));
					end
				end
			end else if (kind < 80) begin
				// broken start: bad note or non-positive duration
				nt = 9'($urandom);
				du = 17'($urandom);
				vo = 9'($urandom);
				if ($urandom_range(1) == 1)
					nt = 9'($urandom_range(128, 511));
				else
					du = ($urandom_range(3) == 0) ? 17'd0 : 17'($urandom_range(65536, 131071));
				send_word(stg_pkg::OP_START, nt, du, vo);
				tick_run($urandom_range(0, 3));
			end else if (kind < 90) begin
				send_word(stg_pkg::OP_STOP, 9'($urandom), 17'($urandom), 9'($urandom));
				tick_run($urandom_range(0, 4));
			end else begin
				// noise: any code with any fields
				n = $urandom_range(1, 8);
				for (int k = 0; k < n; k++)
					send_word(2'($urandom_range(0, 3)), 9'($urandom), 17'($urandom), 9'($urandom));
			end
		end
		steady_flow = 1'b0;
		s_axis_tvalid <= 1'b0;

		// drain, then give the block time to show any stray word
		wait (tone_words_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/stg_pkg.sv
hw/rtl/stg_front.sv
hw/rtl/stg_queue.sv
hw/rtl/stg_back.sv
hw/rtl/square_tone_generator_with_fade.sv
verif/square_tone_generator_with_fade_tb.sv
